// File: hdl/lte_pkg.sv
// Shared types and constants for the LSB text extractor.
// Holds the per-k packing tables, the bit insertion helper and the
// request/response structs of the shared remainder unit. No dependencies.
package lte_pkg;

	localparam int unsigned CHAR_BITS = 8;
	localparam int unsigned HEADER_PIXELS = 3;
	localparam int unsigned NEED_W = 13;

	// Request to the shared remainder unit.
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [6:0] divisor;
	} remu_req_t;

	// Response of the shared remainder unit; rem is valid while done is high.
	typedef struct packed {
		logic       done;
		logic [6:0] rem;
	} remu_rsp_t;

	// Pixels per character, ceil(8/k), indexed by k-1.
	function automatic logic [3:0] ppc_of(input logic [2:0] code);
		logic [3:0] r;
		case (code)
			3'd0: r = 4'd8;
			3'd1: r = 4'd4;
			3'd2: r = 4'd3;
			3'd3: r = 4'd2;
			3'd4: r = 4'd2;
			3'd5: r = 4'd2;
			3'd6: r = 4'd2;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

	// Bits carried by the final pixel of a character, 8-(ppc-1)*k.
	function automatic logic [3:0] last_bits_of(input logic [2:0] code);
		logic [3:0] r;
		case (code)
			3'd0: r = 4'd1;
			3'd1: r = 4'd2;
			3'd2: r = 4'd2;
			3'd3: r = 4'd4;
			3'd4: r = 4'd3;
			3'd5: r = 4'd2;
			3'd6: r = 4'd1;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

	// Shifts n low bits of a pixel into the byte being assembled (n is 1..8).
	function automatic logic [7:0] take_bits(input logic [7:0] acc, input logic [7:0] pix,
			input logic [3:0] n);
		logic [15:0] sh;
		logic [7:0]  msk;
		sh  = {8'h00, acc} << n;
		msk = 8'hFF >> (4'd8 - n);
		return sh[7:0] | (pix & msk);
	endfunction

endpackage

// File: hdl/lsb_text_extract_with_jumps.sv
// Top level of the LSB text extractor with pseudo-random jumps.
// Depends on lte_pkg and on the shared remainder unit lte_remu.
//
// The block takes one pixel low byte per input transaction and recovers a
// hidden text. A pixel with frame_start high opens an image: the least
// significant bits of its first three pixels give k-1, the number of data
// bits per pixel, then a length byte and that many characters follow, each
// packed MSB first into ceil(8/k) pixels. After the length byte and after
// each character that is not the last, a skip of some pixels is derived from
// the remaining padding (pixel_count minus the pixels the message needs,
// floored at zero) and the byte of the pixel just taken. Each recovered byte
// leaves as one output transaction; is_length flags the length byte and last
// flags the final byte of the message. The block works on one pixel at a
// time under a small sequencer. A pixel with no result returns to S_IDLE, and
// one that completes the final byte goes on to S_EMIT. Any other completed
// byte may pass through the shared remainder unit: once for the mod 8k when
// the padding is nonzero and padding ^ pixel is odd and, when that result
// plus one exceeds the padding, a second time for the mod padding+1; the
// length byte first goes through S_NEED and S_PADC to work out the padding.
// A finished byte sits in the output register while the next pixel is
// accepted; the sequencer only waits if a second byte is ready before the
// first is taken. pixel_count is to be written through cfg_we/cfg_data only
// while idle, which the block does not enforce; it is sampled in S_PADC.
module lsb_text_extract_with_jumps #(
	parameter int unsigned PIXEL_COUNT_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [PIXEL_COUNT_BITS-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        frame_start,
	input  logic [7:0]                  pixel_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  character,
	output logic                        is_length,
	output logic                        last
);
	import lte_pkg::*;

	localparam int unsigned PW = PIXEL_COUNT_BITS;
	localparam int unsigned CMP_W = (PW > NEED_W) ? PW : NEED_W;
	localparam logic [PW-1:0] PC_RESET = PW'(65536);

	// Decoding phase of the message.
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_K    = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_TEXT = 4'b1000
	} phase_t;

	// Sequencer that walks one pixel through its steps.
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PIX    = 8'b0000_0010,
		S_NEED   = 8'b0000_0100,
		S_PADC   = 8'b0000_1000,
		S_JSTART = 8'b0001_0000,
		S_MOD1   = 8'b0010_0000,
		S_MOD2   = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} seq_t;

	seq_t              seq_q, seq_n;
	phase_t            phase_q, ph_n;
	logic [PW-1:0]     pc_q;
	logic              fs_q;
	logic [7:0]        pix_q;
	logic [2:0]        bits_q, bits_n;
	logic [3:0]        pic_q, pic_n;
	logic [7:0]        acc_q, acc_n;
	logic [7:0]        chars_q, chars_n;
	logic [6:0]        skip_q, skip_n;
	logic [PW-1:0]     pad_q;
	logic [NEED_W-1:0] need_q;

	// Pending result, waiting for the output register.
	logic              res_pend_q;
	logic [7:0]        res_char_q;
	logic              res_len_q;
	logic              res_last_q;

	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_len_q;
	logic              out_last_q;

	// Per-pixel decode results.
	logic              clr_pad;
	logic              done_byte;
	logic              pix_res;
	logic              pix_len;
	logic              pix_last;
	logic [3:0]        ppc;
	logic [3:0]        kbits;
	logic [3:0]        nbits;
	logic [3:0]        pic_inc;

	// Jump arithmetic.
	logic [7:0]        jv;
	logic [6:0]        j1;
	logic              j1_fits;
	logic [6:0]        jump;
	logic              jump_done;
	logic              out_free;
	logic [CMP_W-1:0]  pc_x;
	logic [CMP_W-1:0]  need_x;
	logic [CMP_W-1:0]  pad_diff;
	logic [NEED_W-1:0] need_prod;

	remu_req_t         rreq;
	remu_rsp_t         rrsp;

	lte_remu u_remu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	assign in_ready  = (seq_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign character = out_char_q;
	assign is_length = out_len_q;
	assign last      = out_last_q;
	assign out_free  = !out_valid_q || out_ready;

	// One pixel through the decoder state; only applied in S_PIX.
	always_comb begin
		ph_n      = phase_q;
		bits_n    = bits_q;
		pic_n     = pic_q;
		acc_n     = acc_q;
		chars_n   = chars_q;
		skip_n    = skip_q;
		clr_pad   = 1'b0;
		done_byte = 1'b0;
		pix_res   = 1'b0;
		pix_len   = 1'b0;
		pix_last  = 1'b0;
		// A new frame abandons whatever message was in progress.
		if (fs_q) begin
			ph_n    = PH_K;
			bits_n  = 3'd0;
			pic_n   = 4'd0;
			acc_n   = 8'd0;
			chars_n = 8'd0;
			skip_n  = 7'd0;
			clr_pad = 1'b1;
		end
		ppc     = ppc_of(bits_n);
		kbits   = {1'b0, bits_n} + 4'd1;
		pic_inc = pic_n + 4'd1;
		nbits   = (pic_inc >= ppc) ? last_bits_of(bits_n) : kbits;
		case (ph_n)
			PH_K: begin
				case (pic_n)
					4'd0: bits_n[2] = pix_q[0];
					4'd1: bits_n[1] = pix_q[0];
					default: bits_n[0] = pix_q[0];
				endcase
				pic_n = pic_inc;
				if (pic_inc >= 4'(HEADER_PIXELS)) begin
					pic_n = 4'd0;
					acc_n = 8'd0;
					ph_n  = PH_LEN;
				end
			end
			PH_LEN: begin
				acc_n = take_bits(acc_n, pix_q, nbits);
				pic_n = pic_inc;
				if (pic_inc >= ppc) begin
					pic_n     = 4'd0;
					done_byte = 1'b1;
					chars_n   = acc_n;
					pix_res   = 1'b1;
					pix_len   = 1'b1;
					pix_last  = (acc_n == 8'd0);
					ph_n      = (acc_n == 8'd0) ? PH_IDLE : PH_TEXT;
				end
			end
			PH_TEXT: begin
				if (skip_n != 7'd0) begin
					skip_n = skip_n - 7'd1;
				end else begin
					acc_n = take_bits(acc_n, pix_q, nbits);
					pic_n = pic_inc;
					if (pic_inc >= ppc) begin
						pic_n     = 4'd0;
						done_byte = 1'b1;
						chars_n   = chars_n - 8'd1;
						pix_res   = 1'b1;
						pix_last  = (chars_n == 8'd0);
						ph_n      = (chars_n == 8'd0) ? PH_IDLE : PH_TEXT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Padding left after the message: pixel_count - (length+1)*ppc - 3, floored at zero.
	assign need_prod = NEED_W'({1'b0, chars_q} + 9'd1) * NEED_W'(ppc_of(bits_q));
	assign pc_x      = CMP_W'(pc_q);
	assign need_x    = CMP_W'(need_q);
	assign pad_diff  = pc_x - need_x;

	// Skip length: for odd v = (padding ^ pixel) mod 256, ((v mod 8k)+1) mod (padding+1).
	assign jv      = pad_q[7:0] ^ pix_q;
	assign j1      = rrsp.rem + 7'd1;
	assign j1_fits = (PW'(j1) <= pad_q);

	always_comb begin
		rreq.start    = 1'b0;
		rreq.dividend = jv;
		rreq.divisor  = {1'b0, bits_q, 3'b000} + 7'd8;
		jump_done     = 1'b0;
		jump          = 7'd0;
		case (seq_q)
			S_JSTART: begin
				rreq.start = (pad_q != '0) && jv[0];
			end
			S_MOD1: begin
				if (rrsp.done) begin
					if (j1_fits) begin
						jump_done = 1'b1;
						jump      = j1;
					end else begin
						// Padding is below 64 here, so padding+1 fits the divisor.
						rreq.start    = 1'b1;
						rreq.dividend = {1'b0, j1};
						rreq.divisor  = pad_q[6:0] + 7'd1;
					end
				end
			end
			S_MOD2: begin
				if (rrsp.done) begin
					jump_done = 1'b1;
					jump      = rrsp.rem;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		seq_n = seq_q;
		case (seq_q)
			S_IDLE: begin
				if (in_valid) begin
					seq_n = S_PIX;
				end
			end
			S_PIX: begin
				if (!done_byte) begin
					seq_n = S_IDLE;
				end else if (pix_last) begin
					seq_n = S_EMIT;
				end else if (pix_len) begin
					seq_n = S_NEED;
				end else begin
					seq_n = S_JSTART;
				end
			end
			S_NEED: seq_n = S_PADC;
			S_PADC: seq_n = S_JSTART;
			S_JSTART: begin
				seq_n = rreq.start ? S_MOD1 : S_EMIT;
			end
			S_MOD1: begin
				if (rrsp.done) begin
					seq_n = j1_fits ? S_EMIT : S_MOD2;
				end
			end
			S_MOD2: begin
				if (rrsp.done) begin
					seq_n = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!res_pend_q || out_free) begin
					seq_n = S_IDLE;
				end
			end
			default: seq_n = S_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			phase_q     <= PH_IDLE;
			pc_q        <= PC_RESET;
			bits_q      <= 3'd0;
			pic_q       <= 4'd0;
			acc_q       <= 8'd0;
			chars_q     <= 8'd0;
			skip_q      <= 7'd0;
			pad_q       <= '0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_n;
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
			if (seq_q == S_PIX) begin
				phase_q <= ph_n;
				bits_q  <= bits_n;
				pic_q   <= pic_n;
				acc_q   <= done_byte ? 8'd0 : acc_n;
				chars_q <= chars_n;
				skip_q  <= skip_n;
				if (clr_pad) begin
					pad_q <= '0;
				end
				res_pend_q <= pix_res;
			end
			if (seq_q == S_PADC) begin
				pad_q <= (pc_x >= need_x) ? PW'(pad_diff) : '0;
			end
			if (jump_done) begin
				pad_q  <= pad_q - PW'(jump);
				skip_q <= jump;
			end
			if (seq_q == S_EMIT && res_pend_q && out_free) begin
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			fs_q  <= frame_start;
			pix_q <= pixel_byte;
		end
		if (seq_q == S_PIX && pix_res) begin
			res_char_q <= acc_n;
			res_len_q  <= pix_len;
			res_last_q <= pix_last;
		end
		if (seq_q == S_NEED) begin
			need_q <= need_prod + NEED_W'(HEADER_PIXELS);
		end
		if (seq_q == S_EMIT && res_pend_q && out_free) begin
			out_char_q <= res_char_q;
			out_len_q  <= res_len_q;
			out_last_q <= res_last_q;
		end
	end

endmodule

// File: hdl/lte_remu.sv
// Shared restoring remainder unit: 8-bit dividend by 7-bit nonzero divisor.
// One dividend bit per cycle; depends on lte_pkg for its request/response structs.
module lte_remu (
	input  logic              clk,
	input  logic              arst_n,
	input  lte_pkg::remu_req_t req,
	output lte_pkg::remu_rsp_t rsp
);
	import lte_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] dvd_q;
	logic [6:0] div_q;
	logic [6:0] rem_q;
	logic [7:0] trial;
	logic [7:0] diff;

	assign trial = {rem_q, dvd_q[7]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= 7'd0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			// The partial remainder stays below the divisor, so 7 bits hold it.
			rem_q <= (trial >= {1'b0, div_q}) ? diff[6:0] : trial[6:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: tb/sv/lsb_text_extract_with_jumps_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lsb_text_extract_with_jumps.
// Depends on lte_pkg and the block's RTL; carries its own bit-exact decoder
// model and compares every recovered byte against it or against a directed row.

module lsb_text_extract_with_jumps_tb;
	import lte_pkg::*;

	localparam int unsigned CNT_W = 24;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned HOLD_OFF_CYCLES = 400;  // long receiver stall, fills the block
	localparam int unsigned HOLD_OFF_AFTER = 60;    // bytes seen before that stall starts
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET = 600;
	localparam int unsigned MIN_SETTINGS = 2;

	// Decoder states, in the order the block walks through them.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_KBITS  = 4'b0010,
		ST_LENGTH = 4'b0100,
		ST_TEXT   = 4'b1000
	} dec_state_t;

	// One recovered byte as the output channel presents it.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_len;
		logic       lst;
	} decoded_t;

	// One pixel transaction. When given is set, the expected outcome is the one
	// typed into the row (has_out and the byte fields) instead of the model's.
	typedef struct packed {
		logic       fs;
		logic [7:0] px;
		logic       given;
		logic       has_out;
		logic [7:0] ch;
		logic       is_len;
		logic       lst;
	} pixel_txn_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             frame_start = 1'b0;
	logic [7:0]       pixel_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       character;
	logic             is_length;
	logic             last;

	lsb_text_extract_with_jumps #(
		.PIXEL_COUNT_BITS(CNT_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_start(frame_start),
		.pixel_byte (pixel_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.is_length  (is_length),
		.last       (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Directed rows. Where the outcome is obvious it is typed in; the rest go
	// through the decoder model like the random traffic does.
	pixel_txn_t dir_rows [0:23] = '{
		// A pixel before any frame start is ignored.
		'{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		// A frame that is abandoned after one header pixel.
		'{1'b1, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		// Restart with k = 8 and an empty message: one length byte, flagged last.
		'{1'b1, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h03, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
		// k = 8, two characters; the pixel bytes keep every jump at zero.
		'{1'b1, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h02, 1'b1, 1'b1, 8'h02, 1'b1, 1'b0},
		'{1'b0, 8'h42, 1'b1, 1'b1, 8'h42, 1'b0, 1'b0},
		'{1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b1},
		// Once the message has ended the block is idle again.
		'{1'b0, 8'h33, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		// k = 1: eight one-bit pixels for the length byte, here zero.
		'{1'b1, 8'hFE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'hFE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h02, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h10, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'h7E, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 8'hF0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1}
	};

	// Decoder model state and its copy of the pixel_count register.
	logic [CNT_W-1:0] img_pixels = CNT_W'(65536);
	dec_state_t       dec_state = ST_IDLE;
	logic [2:0]       dec_code = '0;
	logic [3:0]       dec_pix_idx = '0;
	logic [7:0]       dec_acc = '0;
	logic [7:0]       dec_left = '0;
	logic [CNT_W-1:0] dec_pad = '0;
	logic [6:0]       dec_skip = '0;
	logic [7:0]       dec_prev = '0;

	pixel_txn_t  pixel_q[$];
	decoded_t    pending_bytes[$];
	int unsigned pixels_queued = 0;
	int unsigned pixels_taken = 0;
	int unsigned useful_pixels = 0;
	int unsigned idle_pixels = 0;
	int unsigned bytes_seen = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 0;
	bit          calm = 1'b0;

	// Shifts the low bits of one pixel into the byte in progress, MSB first.
	// The final pixel of a byte carries only the bits that are still missing.
	task automatic absorb_pixel(input logic [7:0] b, output bit done);
		int unsigned k, ppc, nb, acc;
		k = dec_code + 1;
		ppc = (CHAR_BITS + k - 1) / k;
		nb = (dec_pix_idx + 1 >= ppc) ? CHAR_BITS - (ppc - 1) * k : k;
		acc = ((int'(dec_acc) << nb) | (int'(b) & ((1 << nb) - 1))) & 'hFF;
		dec_acc = acc[7:0];
		dec_pix_idx++;
		done = (dec_pix_idx >= ppc);
		if (done) begin
			dec_pix_idx = '0;
		end
	endtask

	// Works out how many pixels to skip before the next character. The skip
	// only happens on an odd seed and never exceeds the padding left.
	task automatic plan_jump();
		int unsigned k, v, j;
		k = dec_code + 1;
		j = 0;
		if (dec_pad != 0) begin
			v = int'(dec_pad[7:0] ^ dec_prev);
			if (v % 2 == 1) begin
				j = v % (CHAR_BITS * k) + 1;
				j = j % (32'(dec_pad) + 1);
			end
			dec_pad = dec_pad - CNT_W'(j);
			dec_skip = 7'(j);
		end
	endtask

	// Advances the decoder model by one accepted pixel.
	task automatic decode_pixel(input logic fs, input logic [7:0] b, output bit got,
			output decoded_t d);
		bit          done;
		int unsigned k, need;
		got = 1'b0;
		d = '0;
		if (fs) begin
			dec_state = ST_KBITS;
			dec_code = '0;
			dec_pix_idx = '0;
			dec_acc = '0;
			dec_left = '0;
			dec_pad = '0;
			dec_skip = '0;
		end
		case (dec_state)
			ST_KBITS: begin
				dec_code[2 - dec_pix_idx] = b[0];
				dec_pix_idx++;
				if (dec_pix_idx >= HEADER_PIXELS) begin
					dec_pix_idx = '0;
					dec_acc = '0;
					dec_state = ST_LENGTH;
				end
			end
			ST_LENGTH: begin
				absorb_pixel(b, done);
				if (done) begin
					// Padding is what the image has beyond the message, floored at zero.
					k = dec_code + 1;
					need = (dec_acc + 1) * ((CHAR_BITS + k - 1) / k) + HEADER_PIXELS;
					dec_left = dec_acc;
					dec_pad = (32'(img_pixels) >= need) ? img_pixels - CNT_W'(need) : '0;
					got = 1'b1;
					d.ch = dec_acc;
					d.is_len = 1'b1;
					d.lst = (dec_left == 0);
					dec_acc = '0;
					dec_prev = b;
					if (dec_left == 0) begin
						dec_state = ST_IDLE;
					end else begin
						dec_state = ST_TEXT;
						plan_jump();
					end
				end
			end
			ST_TEXT: begin
				if (dec_skip > 0) begin
					dec_skip--;
				end else begin
					absorb_pixel(b, done);
					if (done) begin
						dec_left--;
						got = 1'b1;
						d.ch = dec_acc;
						d.is_len = 1'b0;
						d.lst = (dec_left == 0);
						dec_acc = '0;
						dec_prev = b;
						if (dec_left == 0) begin
							dec_state = ST_IDLE;
						end else begin
							plan_jump();
						end
					end
				end
			end
			default: begin
			end
		endcase
		dec_prev = b;
	endtask

	// Called once per accepted input transaction: runs the model and queues
	// the byte that this pixel should produce, if any.
	task automatic record_pixel(input pixel_txn_t t);
		bit       got;
		decoded_t d;
		if (dec_state == ST_IDLE && !t.fs) begin
			idle_pixels++;
		end else begin
			useful_pixels++;
		end
		decode_pixel(t.fs, t.px, got, d);
		if (t.given) begin
			got = t.has_out;
			d.ch = t.ch;
			d.is_len = t.is_len;
			d.lst = t.lst;
		end
		if (got) begin
			pending_bytes.push_back(d);
		end
		pixels_taken++;
	endtask

	task automatic push_data(input logic fs, input logic [7:0] px);
		pixel_txn_t t;
		t = '0;
		t.fs = fs;
		t.px = px;
		pixel_q.push_back(t);
		pixels_queued++;
	endtask

	// Builds one image: a header for k, the length byte, then random text
	// pixels, enough to finish the message including its skips. If the image
	// is too small for the message, exactly what the message needs is sent.
	// A cut image stops at a random point inside the text.
	task automatic queue_message(input int unsigned k, input int unsigned len, input bit cut);
		int unsigned ppc, lastw, used, nb, field, need, span, total;
		logic [7:0]  mask;
		ppc = (CHAR_BITS + k - 1) / k;
		lastw = CHAR_BITS - (ppc - 1) * k;
		for (int i = 0; i < HEADER_PIXELS; i++) begin
			push_data(i == 0, 8'($urandom_range(0, 255) & 'hFE) | 8'(((k - 1) >> (2 - i)) & 1));
		end
		used = 0;
		for (int i = 0; i < ppc; i++) begin
			nb = (i == ppc - 1) ? lastw : k;
			used += nb;
			field = (len >> (CHAR_BITS - used)) & ((1 << nb) - 1);
			mask = 8'((1 << nb) - 1);
			push_data(1'b0, (8'($urandom_range(0, 255)) & ~mask) | 8'(field));
		end
		need = HEADER_PIXELS + (len + 1) * ppc;
		span = need + len * CHAR_BITS * k;
		if (32'(img_pixels) < need) begin
			span = need;
		end else if (32'(img_pixels) < span) begin
			span = 32'(img_pixels);
		end
		total = span - HEADER_PIXELS - ppc;
		if (cut) begin
			total = $urandom_range(0, total);
		end
		repeat (total) push_data(1'b0, 8'($urandom_range(0, 255)));
	endtask

	// Register writes happen only with the block idle, so the model can take
	// the new value at once.
	task automatic write_pixel_count(input logic [CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		img_pixels = value;
		settings_used++;
	endtask

	// Waits until every queued pixel has been accepted and every expected byte
	// has come out, then gives the block time to finish skips that produce
	// no output.
	task automatic wait_drained();
		while (pixel_q.size() != 0 || pixels_taken != pixels_queued ||
				pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic int unsigned pick_stall();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 4);
		end else if (r < 98) begin
			return $urandom_range(5, 15);
		end
		return $urandom_range(30, 100);
	endfunction

	// Sender: offers queued pixels and keeps valid and the payload steady until
	// the transaction is taken. When another pixel follows with no gap, valid
	// stays high and only the payload moves on.
	initial begin : pixel_sender
		pixel_txn_t  cur;
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			while (pixel_q.size() == 0) @(posedge clk);
			cur = pixel_q.pop_front();
			in_valid <= 1'b1;
			frame_start <= cur.fs;
			pixel_byte <= cur.px;
			do @(posedge clk); while (!in_ready);
			record_pixel(cur);
			gap = pick_gap();
			if (gap > 0 || pixel_q.size() == 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Receiver: checks each output transaction against the oldest expected
	// byte, with random back-pressure and one long hold-off that lets the block
	// fill up and stall its input.
	initial begin : byte_receiver
		decoded_t    want;
		int unsigned stall;
		bit          held_off;
		stall = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				bytes_seen++;
				if (pending_bytes.size() == 0) begin
					$error("unexpected byte: character=%02h is_length=%0b last=%0b",
						character, is_length, last);
					mismatches++;
				end else begin
					want = pending_bytes.pop_front();
					if (character !== want.ch) begin
						$error("character: expected %02h, got %02h", want.ch, character);
						mismatches++;
					end
					if (is_length !== want.is_len) begin
						$error("is_length: expected %0b, got %0b", want.is_len, is_length);
						mismatches++;
					end
					if (last !== want.lst) begin
						$error("last: expected %0b, got %0b", want.lst, last);
						mismatches++;
					end
				end
			end
			if (!held_off && bytes_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_stall();
			end
		end
	end

	// Watchdog: a run that moves no transaction on either side for too long is
	// stuck.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog: no transaction for %0d cycles, %0d bytes still expected.",
			WATCHDOG_LIMIT, pending_bytes.size());
		$display("** lsb_text_extract_with_jumps: FAILED **");
		$finish;
	end

	// Main sequence: reset, the directed rows at the reset value of
	// pixel_count, then one phase per pixel_count setting. The first two settings
	// are the extremes; in the smallest image a 255-character message runs
	// far past the image. Most images are complete messages with random
	// content, some are cut short, and some are plain noise with stray frame
	// starts. New images stop once enough pixels have been queued.
	initial begin : main_sequence
		logic [CNT_W-1:0] setting;
		int unsigned      nframes, pick, k, len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			pixel_q.push_back(dir_rows[i]);
			pixels_queued++;
		end
		wait_drained();

		for (int p = 0; p < MIN_SETTINGS || pixels_queued < ITEM_TARGET; p++) begin
			case (p)
				0: setting = CNT_W'(4);
				1: setting = '1;
				2: setting = CNT_W'(65536);
				default: begin
					case ($urandom_range(0, 3))
						0: setting = CNT_W'($urandom_range(4, 30));
						1: setting = CNT_W'($urandom_range(31, 300));
						2: setting = CNT_W'($urandom_range(301, 70000));
						default: setting = CNT_W'($urandom_range('hF00000, 'hFFFFFF));
					endcase
				end
			endcase
			write_pixel_count(setting);
			calm = ($urandom_range(0, 3) == 0);
			if (p == 0) begin
				queue_message(8, 255, 1'b0);
			end
			nframes = $urandom_range(3, 6);
			for (int f = 0; f < nframes; f++) begin
				if (f > 0 && pixels_queued >= ITEM_TARGET) begin
					break;
				end
				pick = $urandom_range(0, 9);
				k = $urandom_range(1, 8);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
				if (pick == 0) begin
					repeat ($urandom_range(1, 30)) begin
						push_data($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)));
					end
				end else begin
					queue_message(k, len, pick == 1);
				end
				// Trailing pixels after a finished message must be ignored.
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3)) push_data(1'b0, 8'($urandom_range(0, 255)));
				end
			end
			wait_drained();
		end

		$display("Run covered %0d decoded pixels and %0d idle ones, %0d recovered bytes,",
			useful_pixels, idle_pixels, bytes_seen);
		$display("over %0d pixel_count settings with random gaps and back-pressure.",
			settings_used);
		if (mismatches == 0) begin
			$display("** lsb_text_extract_with_jumps: PASSED **");
		end else begin
			$display("** lsb_text_extract_with_jumps: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/lte_pkg.sv
hdl/lte_remu.sv
hdl/lsb_text_extract_with_jumps.sv
tb/sv/lsb_text_extract_with_jumps_tb.sv
